// File: rtl/ffam_pkg.sv
// Package for the finite float argmax block: widths, constants, types, the finite test
// and the order key function. No dependencies.
`default_nettype none
package ffam_pkg;
  localparam int unsigned ValueW = 32;
  localparam int unsigned IndexW = 24;
  localparam logic [IndexW-1:0] LastIndex = {IndexW{1'b1}};
  localparam logic [ValueW-1:0] NegInfBits = 32'hFF80_0000;

  typedef logic [ValueW-1:0] value_t;
  typedef logic [IndexW-1:0] index_t;

  typedef struct packed {
    value_t value_bits;
    logic   last;
  } in_item_t;

  typedef struct packed {
    index_t best_index;
    value_t best_value_bits;
    logic   too_long;
  } out_item_t;

  function automatic logic value_finite(input value_t b);
    return b[30:23] != 8'hFF;
  endfunction

  function automatic value_t order_key(input value_t b);
    value_t k;
    if (b[30:0] == 31'd0) begin
      k = 32'h8000_0000;
    end else if (b[31]) begin
      k = ~b;
    end else begin
      k = b | 32'h8000_0000;
    end
    return k;
  endfunction
endpackage
`default_nettype wire

// File: rtl/ffam_in_if.sv
// Input channel interface of the argmax block.
// Depends on ffam_pkg.
`default_nettype none
interface ffam_in_if;
  logic valid;
  logic ready;
  ffam_pkg::value_t value_bits;
  logic last;
  modport source (output valid, value_bits, last, input ready);
  modport sink (input valid, value_bits, last, output ready);
endinterface
`default_nettype wire

// File: rtl/ffam_out_if.sv
// Result channel interface of the argmax block.
// Depends on ffam_pkg.
`default_nettype none
interface ffam_out_if;
  logic valid;
  logic ready;
  ffam_pkg::index_t best_index;
  ffam_pkg::value_t best_value_bits;
  logic too_long;
  modport source (output valid, best_index, best_value_bits, too_long, input ready);
  modport sink (input valid, best_index, best_value_bits, too_long, output ready);
endinterface
`default_nettype wire

// File: rtl/ffam_scan.sv
// Running compare-and-select over the elements of one vector.
// Depends on ffam_pkg.
`default_nettype none
module ffam_scan (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire ffam_pkg::in_item_t  item,
  output ffam_pkg::out_item_t      result
);
  import ffam_pkg::*;

  value_t best_r, best_nxt;
  index_t bidx_r, bidx_nxt;
  index_t pos_r, pos_nxt;
  logic   ovf_r, ovf_nxt;
  logic   upd;

  always_comb begin
    best_nxt = best_r;
    bidx_nxt = bidx_r;
    pos_nxt  = pos_r;
    ovf_nxt  = ovf_r;
    upd = !ovf_r && value_finite(item.value_bits) &&
          (order_key(item.value_bits) > order_key(best_r));
    if (upd) begin
      best_nxt = item.value_bits;
      bidx_nxt = pos_r;
    end
    if (!ovf_r) begin
      if (pos_r == LastIndex) begin
        if (!item.last) begin
          ovf_nxt = 1'b1;
        end
      end else begin
        pos_nxt = pos_r + index_t'(1);
      end
    end
    result.best_index      = bidx_nxt;
    result.best_value_bits = best_nxt;
    result.too_long        = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= NegInfBits;
      bidx_r <= '0;
      pos_r  <= '0;
      ovf_r  <= 1'b0;
    end else if (take) begin
      if (item.last) begin
        best_r <= NegInfBits;
        bidx_r <= '0;
        pos_r  <= '0;
        ovf_r  <= 1'b0;
      end else begin
        best_r <= best_nxt;
        bidx_r <= bidx_nxt;
        pos_r  <= pos_nxt;
        ovf_r  <= ovf_nxt;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/finite_float_argmax_top.sv
// Top level of the finite float argmax block: input register, scan, result register.
// Depends on ffam_pkg, ffam_in_if, ffam_out_if and ffam_scan.
//
// The block takes one element per cycle, unless a full result register stalls a last
// element, and gives one result per vector; a held result keeps accepting elements
// until a new last element finds the result register still full. The last element is
// captured by the input register when accepted, and the compare-and-select writes
// the result register from it once that register is free or being read. Indexes
// saturate at 2^24-1.
`default_nettype none
module finite_float_argmax_top (
  input wire logic clk,
  input wire logic rst_n,
  ffam_in_if.sink   in_ch,
  ffam_out_if.source out_ch
);
  import ffam_pkg::*;

  in_item_t  in_r;
  logic      in_vld_r;
  out_item_t res, out_r;
  logic      out_vld_r;
  logic      take, in_rdy;

  assign take   = in_vld_r && (!in_r.last || !out_vld_r || out_ch.ready);
  assign in_rdy = !in_vld_r || take;
  assign in_ch.ready = in_rdy;

  ffam_scan u_scan (.clk(clk), .rst_n(rst_n), .take(take), .item(in_r), .result(res));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_rdy) in_vld_r <= in_ch.valid;
      if (take && in_r.last) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      in_r.value_bits <= in_ch.value_bits;
      in_r.last       <= in_ch.last;
    end
    if (take && in_r.last) out_r <= res;
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.best_index      = out_r.best_index;
  assign out_ch.best_value_bits = out_r.best_value_bits;
  assign out_ch.too_long        = out_r.too_long;
endmodule
`default_nettype wire

// File: rtl/ffam_checker.sv
// Port-level checks of the argmax block, bound to the top level.
// Depends on ffam_pkg.
`default_nettype none
module ffam_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire ffam_pkg::value_t out_best_value_bits,
  input wire ffam_pkg::index_t out_best_index,
  input wire logic in_ready
);
  import ffam_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_value_bits))
    else $error("stalled result changed");
  a_finite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !value_finite(out_best_value_bits) |->
      out_best_value_bits == NegInfBits && out_best_index == '0)
    else $error("non-finite result not minus infinity at index zero");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");
endmodule

bind finite_float_argmax_top ffam_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_best_value_bits(out_ch.best_value_bits), .out_best_index(out_ch.best_index),
  .in_ready(in_ch.ready)
);
`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for finite_float_argmax_top: a queue-fed driver, an
// acceptance-time argmax predictor and a result monitor.
// Depends on ffam_pkg, ffam_in_if, ffam_out_if and the top level RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffam_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  ffam_in_if  in_ch();
  ffam_out_if out_ch();

  finite_float_argmax_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  in_item_t  pending_elems[$];
  out_item_t expected_argmax[$];
  int unsigned sent_count = 0;
  int unsigned accepted_count = 0;
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  value_t scan_best_value = NegInfBits;
  index_t scan_best_index = '0;
  index_t scan_position = '0;
  logic   scan_overflowed = 1'b0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.value_bits = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [31:0] rank_of(input value_t b);
    if (b[30:0] == 31'd0) return 32'h8000_0000;
    if (b[31]) return ~b;
    return {1'b1, b[30:0]};
  endfunction

  task automatic advance_scan(input in_item_t it);
    if (!scan_overflowed) begin
      if (it.value_bits[30:23] != 8'hFF &&
          rank_of(it.value_bits) > rank_of(scan_best_value)) begin
        scan_best_value = it.value_bits;
        scan_best_index = scan_position;
      end
      if (scan_position == LastIndex) begin
        if (!it.last) scan_overflowed = 1'b1;
      end else begin
        scan_position = scan_position + 1'b1;
      end
    end
    if (it.last) begin
      expected_argmax.push_back('{scan_best_index, scan_best_value, scan_overflowed});
      scan_best_value = NegInfBits;
      scan_best_index = '0;
      scan_position = '0;
      scan_overflowed = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("ERROR %0t: %s got 0x%08h expected 0x%08h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_elems.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.value_bits <= pending_elems[0].value_bits;
        in_ch.last <= pending_elems[0].last;
        void'(pending_elems.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      advance_scan('{in_ch.value_bits, in_ch.last});
      accepted_count++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_argmax.size() == 0) begin
        report_mismatch("unexpected result index", 32'(out_ch.best_index), 32'd0);
      end else begin
        want = expected_argmax.pop_front();
        if (out_ch.best_index !== want.best_index)
          report_mismatch("best_index", 32'(out_ch.best_index), 32'(want.best_index));
        if (out_ch.best_value_bits !== want.best_value_bits)
          report_mismatch("best_value_bits", out_ch.best_value_bits, want.best_value_bits);
        if (out_ch.too_long !== want.too_long)
          report_mismatch("too_long", 32'(out_ch.too_long), 32'(want.too_long));
      end
    end
  end

  task automatic queue_elem(input value_t v, input logic lst);
    pending_elems.push_back('{v, lst});
    sent_count++;
  endtask

  function automatic value_t random_value(input value_t prev);
    value_t v;
    v = $urandom();
    case ($urandom_range(11))
      0: v[30:23] = 8'hFF;
      1: v = {v[31], 8'hFF, 23'd0};
      2: v = {v[31], 31'd0};
      3: v[30:23] = 8'h00;
      4: v = {v[31], 31'h7F7F_FFFF};
      5, 6: v = prev;
      7: v[30:23] = 8'h7F ^ {6'd0, v[24:23]};
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_random_vectors(input int unsigned n_elems);
    int unsigned len;
    value_t prev;
    prev = $urandom();
    while (n_elems > 0) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
      for (int unsigned i = 0; i < len; i++) begin
        prev = random_value(prev);
        queue_elem(prev, i == len - 1);
      end
      n_elems = (n_elems > len) ? n_elems - len : 0;
    end
  endtask

  task automatic drain();
    wait (pending_elems.size() == 0 && accepted_count == sent_count &&
          expected_argmax.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    queue_elem(32'h7FC0_0000, 1'b0);
    queue_elem(32'h7F80_0000, 1'b0);
    queue_elem(32'hFF80_0000, 1'b0);
    queue_elem(32'hFFFF_FFFF, 1'b1);
    queue_elem(32'h0000_0000, 1'b0);
    queue_elem(32'h8000_0000, 1'b1);
    queue_elem(32'h8000_0000, 1'b0);
    queue_elem(32'h0000_0000, 1'b1);
    queue_elem(32'hFF7F_FFFF, 1'b0);
    queue_elem(32'h7F7F_FFFF, 1'b0);
    queue_elem(32'h7F7F_FFFF, 1'b1);
    queue_elem(32'h0000_0001, 1'b0);
    queue_elem(32'h8000_0001, 1'b0);
    queue_elem(32'h7F80_0001, 1'b1);
    queue_elem(32'h3F80_0000, 1'b1);
    queue_elem(32'hBF80_0000, 1'b0);
    queue_elem(32'hC000_0000, 1'b0);
    queue_elem(32'hBF80_0000, 1'b1);
    drain();

    send_idle_pct = 0;  recv_stall_pct = 0;  queue_random_vectors(220); drain();
    send_idle_pct = 77; recv_stall_pct = 0;  queue_random_vectors(210); drain();
    send_idle_pct = 0;  recv_stall_pct = 77; queue_random_vectors(210); drain();
    send_idle_pct = 37; recv_stall_pct = 37; queue_random_vectors(210); drain();

    if (error_count == 0) begin
      $display("finite_float_argmax_top regression: pass");
    end else begin
      $display("finite_float_argmax_top regression: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("finite_float_argmax_top regression: fail");
    $finish;
  end
endmodule
